/* hw/rtl/key_length_value_record_parser_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the key/length/value record parser
// Concurrent checks clocked by clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef KEY_LENGTH_VALUE_RECORD_PARSER_ASSERT_SVH
`define KEY_LENGTH_VALUE_RECORD_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property at every rising edge outside reset
`define KLV_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("klv check failed");

// Check that a condition never holds
`define KLV_NEVER(label, expr) \
	`KLV_ASSERT(label, !(expr))

`else

`define KLV_ASSERT(label, prop)
`define KLV_NEVER(label, expr)

`endif

`endif

/* hw/rtl/klv_pkg.sv */
// ----------------------------------------------------------------------------
// klv_pkg
// Codes, defaults and item types shared by the record parser modules.
// ----------------------------------------------------------------------------
package klv_pkg;

	// Parameter defaults
	localparam int KEY_MAX_DEF     = 32;
	localparam int OFFSET_BITS_DEF = 16;

	// Parser phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_KEY  = 2'd1;
	localparam logic [1:0] PH_LEN  = 2'd2;
	localparam logic [1:0] PH_VAL  = 2'd3;

	// Status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_KEY_LONG   = 3'd1;
	localparam logic [2:0] ST_KEY_SHORT  = 3'd2;
	localparam logic [2:0] ST_LEN_ZERO   = 3'd3;
	localparam logic [2:0] ST_UNFINISHED = 3'd4;

	// Byte classes
	localparam logic [2:0] KIND_PAD = 3'd0;
	localparam logic [2:0] KIND_KEY = 3'd1;
	localparam logic [2:0] KIND_LEN = 3'd2;
	localparam logic [2:0] KIND_VAL = 3'd3;
	localparam logic [2:0] KIND_IGN = 3'd4;

	// One classified input byte
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
		logic       zero;
	} klv_byte_t;

	localparam int BYTE_BITS = $bits(klv_byte_t);

	// One result item
	typedef struct packed {
		logic        region_done;
		logic [15:0] value_start;
		logic [15:0] value_length;
		logic [5:0]  key_length;
		logic        entry_done;
		logic [2:0]  byte_kind;
		logic [2:0]  status;
	} klv_result_t;

endpackage

/* hw/rtl/klv_front.sv */
// ----------------------------------------------------------------------------
// klv_front
// Accepts region bytes, tags each with its region offset and a zero flag.
// ----------------------------------------------------------------------------
module klv_front #(
	parameter int OFFSET_BITS = klv_pkg::OFFSET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             in_data,
	input  logic                   in_first,
	input  logic                   in_last,
	output logic                   push,
	output klv_pkg::klv_byte_t     push_byte,
	output logic [OFFSET_BITS-1:0] push_off,
	input  logic                   queue_full
);
	import klv_pkg::*;

	logic [OFFSET_BITS-1:0] off_q;
	logic [OFFSET_BITS-1:0] cur_off;

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	// Restart the offset at a region start
	assign cur_off = in_first ? '0 : off_q;

	// Classify the byte
	always_comb begin
		push_byte.data  = in_data;
		push_byte.first = in_first;
		push_byte.last  = in_last;
		push_byte.zero  = (in_data == 8'd0);
	end
	assign push_off = cur_off;

	// Advance the offset on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (push) begin
			off_q <= cur_off + OFFSET_BITS'(1);
		end
	end

endmodule

/* hw/rtl/klv_queue.sv */
// ----------------------------------------------------------------------------
// klv_queue
// Two-entry queue between the byte front end and the parser back end.
// ----------------------------------------------------------------------------
`include "key_length_value_record_parser_assert.svh"

module klv_queue #(
	parameter int WIDTH = klv_pkg::BYTE_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             rd_valid,
	output logic [WIDTH-1:0] rd_data
);
	import klv_pkg::*;

	localparam int DEPTH = 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	// Move pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`KLV_NEVER(a_push_full, push && full)
	`KLV_NEVER(a_pop_empty, pop && !rd_valid)
	`KLV_ASSERT(a_count_up, push && !pop |=> count_q == $past(count_q) + CW'(1))

endmodule

/* hw/rtl/klv_back.sv */
// ----------------------------------------------------------------------------
// klv_back
// Record state machine and result register; one byte per cycle while the result is not stalled.
// ----------------------------------------------------------------------------
`include "key_length_value_record_parser_assert.svh"

module klv_back #(
	parameter int KEY_MAX     = klv_pkg::KEY_MAX_DEF,
	parameter int OFFSET_BITS = klv_pkg::OFFSET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   pop,
	input  klv_pkg::klv_byte_t     item,
	input  logic [OFFSET_BITS-1:0] item_off,
	output logic                   res_valid,
	input  logic                   res_ready,
	output klv_pkg::klv_result_t   res
);
	import klv_pkg::*;

	localparam int KW = $clog2(KEY_MAX + 1);

	logic [1:0]             phase_q;
	logic [KW-1:0]          kcnt_q;
	logic                   lbc_q;
	logic [15:0]            vlen_q;
	logic [OFFSET_BITS-1:0] vstart_q;
	logic [2:0]             err_q;

	logic [1:0]             ph;
	logic [KW-1:0]          kc;
	logic                   lb;
	logic [15:0]            vl;
	logic [OFFSET_BITS-1:0] vs;
	logic [2:0]             err;
	logic [OFFSET_BITS-1:0] off_next;
	klv_result_t            res_nxt;
	logic                   valid_q;
	klv_result_t            res_q;

	// Take a byte when the result register is free or being drained
	assign pop       = item_valid && (!valid_q || res_ready);
	assign res_valid = valid_q;
	assign res       = res_q;
	assign off_next  = item_off + OFFSET_BITS'(1);

	// Parse one byte
	always_comb begin
		ph  = item.first ? PH_IDLE : phase_q;
		kc  = item.first ? '0 : kcnt_q;
		lb  = item.first ? 1'b0 : lbc_q;
		vl  = item.first ? 16'd0 : vlen_q;
		vs  = item.first ? '0 : vstart_q;
		err = item.first ? ST_OK : err_q;

		res_nxt              = '0;
		res_nxt.byte_kind    = KIND_IGN;
		res_nxt.region_done  = item.last;

		if (err == ST_OK) begin
			if (ph == PH_IDLE) begin
				if (item.zero) begin
					res_nxt.byte_kind = KIND_PAD;
				end else begin
					ph = PH_KEY;
				end
			end
			unique case (ph)
				PH_KEY: begin
					res_nxt.byte_kind = KIND_KEY;
					kc = kc + KW'(1);
					if (kc >= KW'(KEY_MAX) && !item.zero) begin
						err = ST_KEY_LONG;
					end else if (item.zero && kc <= KW'(1)) begin
						err = ST_KEY_SHORT;
					end else if (item.zero) begin
						ph = PH_LEN;
					end
				end
				PH_LEN: begin
					res_nxt.byte_kind = KIND_LEN;
					if (!lb) begin
						vl = {8'd0, item.data};
						lb = 1'b1;
					end else begin
						vl = {item.data, vl[7:0]};
						lb = 1'b0;
						if (vl == 16'd0) begin
							err = ST_LEN_ZERO;
						end else begin
							ph = PH_VAL;
							vs = off_next;
						end
					end
				end
				PH_VAL: begin
					res_nxt.byte_kind = KIND_VAL;
					if (vs + OFFSET_BITS'(vl) == off_next) begin
						res_nxt.entry_done   = 1'b1;
						res_nxt.key_length   = 6'(kc);
						res_nxt.value_length = vl;
						res_nxt.value_start  = 16'(vs);
						ph = PH_IDLE;
						kc = '0;
						lb = 1'b0;
						vl = 16'd0;
						vs = '0;
					end
				end
				default: begin
				end
			endcase
			if (item.last && err == ST_OK && ph != PH_IDLE) begin
				err = ST_UNFINISHED;
			end
		end
		res_nxt.status = err;
	end

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			kcnt_q   <= '0;
			lbc_q    <= 1'b0;
			vlen_q   <= 16'd0;
			vstart_q <= '0;
			err_q    <= ST_OK;
		end else if (pop) begin
			phase_q  <= ph;
			kcnt_q   <= kc;
			lbc_q    <= lb;
			vlen_q   <= vl;
			vstart_q <= vs;
			err_q    <= err;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_nxt;
		end
	end

	`KLV_ASSERT(a_done_is_value, pop && res_nxt.entry_done |-> res_nxt.byte_kind == KIND_VAL)
	`KLV_ASSERT(a_ignored_has_err, pop && res_nxt.byte_kind == KIND_IGN |-> err != ST_OK)
	`KLV_ASSERT(a_err_sticky, pop && !item.first && err_q != ST_OK |=> err_q == $past(err_q))

endmodule

/* hw/rtl/key_length_value_record_parser.sv */
// ----------------------------------------------------------------------------
// key_length_value_record_parser
// Parses a settings region of key/length/value records, one result per byte.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  s_axis   in   tdata: data_byte; tuser: first_byte; tlast: last_byte
//  m_axis   out  tdata: status..value_start; tuser: byte_kind; tlast: region_done
//
//  One byte per cycle sustained while m_axis_tready stays high; the parser
//  state update in klv_back is combinational, and each byte passes the
//  queue and the result register before its result is offered on m_axis.
//  Reset clears offset, queue, parser state and the result valid flag.
//  A stall on m_axis fills the two-entry queue and then drops s_axis_tready.
// ----------------------------------------------------------------------------
module key_length_value_record_parser #(
	parameter int KEY_MAX     = klv_pkg::KEY_MAX_DEF,
	parameter int OFFSET_BITS = klv_pkg::OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] first_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] status, [3] entry_done, [9:4] key_length,
	// [25:10] value_length, [41:26] value_start, [47:42] zero
	output logic [47:0] m_axis_tdata,
	output logic [2:0]  m_axis_tuser,   // [2:0] byte_kind
	output logic        m_axis_tlast
);
	import klv_pkg::*;

	localparam int QW = BYTE_BITS + OFFSET_BITS;

	logic                   push;
	klv_byte_t              push_byte;
	logic [OFFSET_BITS-1:0] push_off;
	logic                   queue_full;
	logic                   pop;
	logic                   q_valid;
	logic [QW-1:0]          q_data;
	klv_byte_t              q_byte;
	logic [OFFSET_BITS-1:0] q_off;
	klv_result_t            res;

	klv_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_first  (s_axis_tuser),
		.in_last   (s_axis_tlast),
		.push      (push),
		.push_byte (push_byte),
		.push_off  (push_off),
		.queue_full(queue_full)
	);

	klv_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data ({push_off, push_byte}),
		.full    (queue_full),
		.pop     (pop),
		.rd_valid(q_valid),
		.rd_data (q_data)
	);

	// Split queue entry
	assign q_byte = klv_byte_t'(q_data[BYTE_BITS-1:0]);
	assign q_off  = q_data[QW-1:BYTE_BITS];

	klv_back #(
		.KEY_MAX    (KEY_MAX),
		.OFFSET_BITS(OFFSET_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(q_valid),
		.pop       (pop),
		.item      (q_byte),
		.item_off  (q_off),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	// Pack result fields
	assign m_axis_tdata = {6'd0, res.value_start, res.value_length, res.key_length,
		res.entry_done, res.status};
	assign m_axis_tuser = res.byte_kind;
	assign m_axis_tlast = res.region_done;

endmodule
